// ----- design/nnc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnc_pkg
// Shared widths, codes and types of the nearest-neighbour classifier.
// ----------------------------------------------------------------------------
package nnc_pkg;

  localparam int FEAT_W   = 16;
  localparam int LABEL_W  = 4;
  localparam int ENTRY_W  = 5;
  localparam int DIST_W   = 35;
  localparam int IN_FEATS = 5;
  localparam int SQ_W     = 32;

  localparam int PTS_W     = 6;
  localparam int DIMS_W    = 3;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE   = 1'd1;

  localparam logic [PTS_W-1:0]  POINTS_RESET = 6'd20;
  localparam logic [DIMS_W-1:0] DIMS_RESET   = 3'd5;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // tdata layouts
  localparam int IN_ENTRY_LSB = 0;
  localparam int IN_LABEL_LSB = IN_ENTRY_LSB + ENTRY_W;
  localparam int IN_FEAT_LSB  = IN_LABEL_LSB + LABEL_W;
  localparam int IN_TDATA_W   = 96;

  localparam int OUT_LABEL_LSB = 0;
  localparam int OUT_ENTRY_LSB = OUT_LABEL_LSB + LABEL_W;
  localparam int OUT_DIST_LSB  = OUT_ENTRY_LSB + ENTRY_W;
  localparam int OUT_TDATA_W   = 48;

  // status of the distance pipeline towards the sequencer
  typedef struct packed {
    logic valid;
    logic busy;
  } dist_stat_t;

endpackage
`default_nettype wire

// ----- design/nnc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnc_cell
// One slot of the training ring: holds a point and its label, takes a load
// or the contents of its neighbour.
// ----------------------------------------------------------------------------
module nnc_cell #(
  parameter int FV_W = 80
) (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic                       shift,
  input  wire logic [FV_W-1:0]            load_feat,
  input  wire logic [nnc_pkg::LABEL_W-1:0] load_label,
  input  wire logic [FV_W-1:0]            next_feat,
  input  wire logic [nnc_pkg::LABEL_W-1:0] next_label,
  output logic      [FV_W-1:0]            feat,
  output logic      [nnc_pkg::LABEL_W-1:0] label
);

  logic [FV_W-1:0]             feat_r;
  logic [nnc_pkg::LABEL_W-1:0] label_r;

  always_ff @(posedge clk) begin
    if (load) begin
      feat_r  <= load_feat;
      label_r <= load_label;
    end else if (shift) begin
      feat_r  <= next_feat;
      label_r <= next_label;
    end
  end

  assign feat  = feat_r;
  assign label = label_r;

endmodule
`default_nettype wire

// ----- design/nnc_dist.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnc_dist
// Squared Euclidean distance pipeline with registered difference, square
// and sum; one point per cycle.
// ----------------------------------------------------------------------------
module nnc_dist #(
  parameter int DIMS  = 5,
  parameter int IDX_W = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic [IDX_W-1:0]                 in_idx,
  input  wire logic [nnc_pkg::LABEL_W-1:0]      in_label,
  input  wire logic [DIMS*nnc_pkg::FEAT_W-1:0]  q_feat,
  input  wire logic [DIMS*nnc_pkg::FEAT_W-1:0]  p_feat,
  input  wire logic [DIMS-1:0]                  dim_en,
  output nnc_pkg::dist_stat_t                   stat,
  output logic      [IDX_W-1:0]                 out_idx,
  output logic      [nnc_pkg::LABEL_W-1:0]      out_label,
  output logic      [nnc_pkg::SQ_W+$clog2(DIMS)-1:0] out_sum
);

  localparam int FW    = nnc_pkg::FEAT_W;
  localparam int SUM_W = nnc_pkg::SQ_W + $clog2(DIMS);

  logic [2:0]                 vld_r;
  logic [IDX_W-1:0]           idx1_r, idx2_r, idx3_r;
  logic [nnc_pkg::LABEL_W-1:0] lab1_r, lab2_r, lab3_r;

  logic signed [FW:0]            diff_nxt [DIMS];
  logic signed [FW:0]            diff_r   [DIMS];
  logic [nnc_pkg::SQ_W-1:0]      sq_nxt   [DIMS];
  logic [nnc_pkg::SQ_W-1:0]      sq_r     [DIMS];
  logic signed [2*FW+1:0]        prod     [DIMS];
  logic [SUM_W-1:0]              sum_nxt, sum_r;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      // unused dimensions add nothing
      if (dim_en[d]) begin
        diff_nxt[d] = $signed({q_feat[d*FW+FW-1], q_feat[d*FW +: FW]})
                    - $signed({p_feat[d*FW+FW-1], p_feat[d*FW +: FW]});
      end else begin
        diff_nxt[d] = '0;
      end
      prod[d]   = diff_r[d] * diff_r[d];
      sq_nxt[d] = prod[d][nnc_pkg::SQ_W-1:0];
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int d = 0; d < DIMS; d++) begin
      sum_nxt = sum_nxt + SUM_W'(sq_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= in_idx;
    lab1_r <= in_label;
    idx2_r <= idx1_r;
    lab2_r <= lab1_r;
    idx3_r <= idx2_r;
    lab3_r <= lab2_r;
    diff_r <= diff_nxt;
    sq_r   <= sq_nxt;
    sum_r  <= sum_nxt;
  end

  assign stat.valid = vld_r[2];
  assign stat.busy  = |vld_r;
  assign out_idx    = idx3_r;
  assign out_label  = lab3_r;
  assign out_sum    = sum_r;

endmodule
`default_nettype wire

// ----- design/nearest_neighbor_classifier_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_classifier_unit
// 1-nearest-neighbour classifier over a ring of training-point cells.
// ----------------------------------------------------------------------------
// Input items (in_*): tuser = func. A load item (func 0) writes features and
// label into the slot given by entry and gives no result. A query item
// (func 1) gives one result item (out_*): label, slot and squared distance
// of the nearest point among the first points_in_use slots, summed over the
// first dims_in_use features; on a tie the lowest slot wins. A query rotates
// the cell ring once round, one point per cycle into the distance pipeline,
// scanning all MAX_POINTS slots whatever points_in_use holds; the three-stage
// distance pipeline then drains. The result is then registered in the emit
// state, and in_tready returns as it is registered. A new item may be taken
// while a result waits in the output register; a second result waits until
// out_tready takes the first.
// Configuration: cfg_index 0 = points_in_use (reset 20), 1 = dims_in_use
// (reset 5); write only while idle. Reset clears the state, the counter,
// out_tvalid and the configuration but not the stored points or the query
// and result data; read only slots that have been loaded.
// ----------------------------------------------------------------------------
module nearest_neighbor_classifier_unit #(
  parameter int MAX_POINTS = 32,
  parameter int MAX_DIMS   = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tdata: entry[4:0], class_label[8:5], feat0[24:9], feat1[40:25],
  //        feat2[56:41], feat3[72:57], feat4[88:73], zero [95:89]
  input  wire logic [nnc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: func[0]
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: best_label[3:0], best_entry[8:4], best_distance[43:9], zero [47:44]
  output logic      [nnc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_wr_en,
  input  wire logic [nnc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nnc_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int FW    = nnc_pkg::FEAT_W;
  localparam int LW    = nnc_pkg::LABEL_W;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int FV_W  = MAX_DIMS * FW;
  localparam int SUM_W = nnc_pkg::SQ_W + $clog2(MAX_DIMS);
  localparam int LD    = (MAX_DIMS < nnc_pkg::IN_FEATS) ? MAX_DIMS : nnc_pkg::IN_FEATS;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH, S_EMIT} state_t;

  state_t state_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              out_tvalid_r;
  logic [nnc_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic [nnc_pkg::PTS_W-1:0]  points_in_use_r;
  logic [nnc_pkg::DIMS_W-1:0] dims_in_use_r;

  logic [FV_W-1:0]     q_r;
  logic [CNT_W-1:0]    np_r;
  logic [MAX_DIMS-1:0] dim_en_r;
  logic [CNT_W-1:0]    np_nxt;
  logic [MAX_DIMS-1:0] dim_en_nxt;

  logic [SUM_W-1:0]  best_d_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [LW-1:0]     best_label_r;

  logic [FV_W-1:0]   feat_in;
  logic [nnc_pkg::ENTRY_W-1:0] entry_in;
  logic [LW-1:0]     label_in;
  logic              in_acc, load_en, query_go, shift;

  logic [FV_W-1:0]   cell_feat  [MAX_POINTS];
  logic [LW-1:0]     cell_label [MAX_POINTS];

  nnc_pkg::dist_stat_t dist_stat;
  logic [IDX_W-1:0]  dist_idx;
  logic [LW-1:0]     dist_label;
  logic [SUM_W-1:0]  dist_sum;
  logic              feed_valid;

  // unpack the input item
  always_comb begin
    feat_in = '0;
    for (int d = 0; d < LD; d++) begin
      feat_in[d*FW +: FW] = in_tdata[nnc_pkg::IN_FEAT_LSB + d*FW +: FW];
    end
  end

  assign entry_in = in_tdata[nnc_pkg::IN_ENTRY_LSB +: nnc_pkg::ENTRY_W];
  assign label_in = in_tdata[nnc_pkg::IN_LABEL_LSB +: LW];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_en   = in_acc && (in_tuser == nnc_pkg::FUNC_LOAD);
  assign query_go  = in_acc && (in_tuser == nnc_pkg::FUNC_QUERY);
  assign shift     = (state_r == S_SCAN);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_in_use_r <= nnc_pkg::POINTS_RESET;
      dims_in_use_r   <= nnc_pkg::DIMS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nnc_pkg::REG_POINTS_IN_USE: points_in_use_r <= cfg_wdata[nnc_pkg::PTS_W-1:0];
        nnc_pkg::REG_DIMS_IN_USE:   dims_in_use_r   <= cfg_wdata[nnc_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the counts: zero counts as one, saturate at the store size
  always_comb begin
    if (points_in_use_r == '0) begin
      np_nxt = CNT_W'(1);
    end else if (32'(points_in_use_r) > MAX_POINTS) begin
      np_nxt = CNT_W'(MAX_POINTS);
    end else begin
      np_nxt = CNT_W'(points_in_use_r);
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      dim_en_nxt[d] = (d == 0) || ((32'(dims_in_use_r) > d) && (d < MAX_DIMS));
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      q_r      <= feat_in;
      np_r     <= np_nxt;
      dim_en_r <= dim_en_nxt;
    end
  end

  // ring of cells; cell 0 is the head, each cell takes from the one above
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    localparam int NEXT = (k + 1) % MAX_POINTS;
    nnc_cell #(
      .FV_W (FV_W)
    ) u_cell (
      .clk        (clk),
      .load       (load_en && (32'(entry_in) == k)),
      .shift      (shift),
      .load_feat  (feat_in),
      .load_label (label_in),
      .next_feat  (cell_feat[NEXT]),
      .next_label (cell_label[NEXT]),
      .feat       (cell_feat[k]),
      .label      (cell_label[k])
    );
  end

  assign feed_valid = shift && (CNT_W'(cnt_r) < np_r);

  nnc_dist #(
    .DIMS  (MAX_DIMS),
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (feed_valid),
    .in_idx    (cnt_r),
    .in_label  (cell_label[0]),
    .q_feat    (q_r),
    .p_feat    (cell_feat[0]),
    .dim_en    (dim_en_r),
    .stat      (dist_stat),
    .out_idx   (dist_idx),
    .out_label (dist_label),
    .out_sum   (dist_sum)
  );

  // running best; slot 0 always seeds it, ties keep the earlier slot
  always_ff @(posedge clk) begin
    if (dist_stat.valid && ((dist_idx == '0) || (dist_sum < best_d_r))) begin
      best_d_r     <= dist_sum;
      best_idx_r   <= dist_idx;
      best_label_r <= dist_label;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (query_go) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // rotate the full ring so every cell returns to its own slot
          if (cnt_r == IDX_W'(MAX_POINTS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_FLUSH;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        S_FLUSH: begin
          if (!dist_stat.busy) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= nnc_pkg::OUT_TDATA_W'({nnc_pkg::DIST_W'(best_d_r),
                                                   nnc_pkg::ENTRY_W'(best_idx_r),
                                                   best_label_r});
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !dist_stat.busy)
    else $error("distance pipeline busy while idle");

  a_dist_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    dist_stat.valid |-> ((state_r == S_SCAN) || (state_r == S_FLUSH)))
    else $error("distance result outside a query");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");

endmodule
`default_nettype wire
